/* design/bsspwm_pkg.sv */
`default_nettype none

package bsspwm_pkg;

   localparam int CHANNELS_DEFAULT = 6;
   localparam int LEVEL_W          = 6;
   localparam int COUNT_W          = 8;
   localparam int INDEX_W          = 3;

   localparam logic [INDEX_W-1:0] INDEX_MAX   = 3'd7;
   localparam logic [COUNT_W-1:0] START_RESET = 8'd155;
   localparam logic [COUNT_W-1:0] COUNT_TOP   = 8'hFF;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_ADDR = 2'd1,
      OP_DATA = 2'd2,
      OP_IDLE = 2'd3
   } opcode_type;

   typedef struct packed {
      logic               load_en;
      logic               write_en;
      logic [INDEX_W-1:0] write_sel;
      logic [COUNT_W-1:0] duty;
   } chan_ctrl_type;

endpackage

`default_nettype wire

/* design/bus_set_six_channel_pwm_unit.sv */
`default_nettype none

// channel | ports        | tdata / tuser
// --------+--------------+------------------------------------------
// req     | req_t*       | tdata[7:0] data_byte, tuser[1:0] opcode
// rsp     | rsp_t*       | tdata[5:0] pwm_levels, [13:6] count_now
// csr     | csr_*        | csr_data[7:0] period_start
//
// One beat per cycle; each req beat gives one rsp beat from the rsp output register.
// Rate is set by the single rsp output register: req_tready drops only
// while a held rsp beat is stalled.
// Synchronous active-high reset: counter and index zero, compares zero,
// all channels enabled, period_start 155. csr is always ready.

module bus_set_six_channel_pwm_unit #(
   parameter int Channels = bsspwm_pkg::CHANNELS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [5:0] pwm_levels, [13:6] count_now
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data     // [7:0] period_start
);
   import bsspwm_pkg::*;

   logic [COUNT_W-1:0] start_ff;
   logic [COUNT_W-1:0] start_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [INDEX_W-1:0] idx_ff;
   logic [INDEX_W-1:0] idx_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [15:0]        rsp_data_ff;
   logic [15:0]        rsp_data_in;
   logic [LEVEL_W-1:0] levels;
   logic               accept;
   opcode_type         op;
   chan_ctrl_type      ctrl;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = opcode_type'(req_tuser);
   assign csr_ready  = 1'b1;
   assign start_in   = (csr_valid && csr_ready) ? csr_data : start_ff;

   always_comb begin
      count_in       = count_ff;
      idx_in         = idx_ff;
      ctrl.load_en   = 1'b0;
      ctrl.write_en  = 1'b0;
      ctrl.write_sel = '0;
      ctrl.duty      = req_tdata;
      if (accept) begin
         unique case (op)
            OP_TICK: begin
               if (count_ff == COUNT_TOP) begin
                  count_in     = start_ff;
                  ctrl.load_en = 1'b1;
               end else begin
                  count_in = count_ff + 8'd1;
               end
            end
            OP_ADDR: begin
               idx_in = '0;
            end
            OP_DATA: begin
               if (idx_ff != INDEX_MAX) begin
                  idx_in = idx_ff + 3'd1;
               end
               if ((idx_in != '0) && (idx_in <= INDEX_W'(Channels))) begin
                  ctrl.write_en  = 1'b1;
                  ctrl.write_sel = idx_in - 3'd1;
               end
            end
            OP_IDLE: begin
            end
            default: begin
            end
         endcase
      end
   end

   bsspwm_chan_bank #(
      .Channels(Channels)
   ) u_bank (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .period_start(start_ff),
      .count_next  (count_in),
      .levels      (levels)
   );

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_data_in  = {2'b00, count_in, levels};
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= START_RESET;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* design/bsspwm_chan_bank.sv */
`default_nettype none

module bsspwm_chan_bank #(
   parameter int Channels = bsspwm_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bsspwm_pkg::chan_ctrl_type      ctrl,
   input  wire logic [bsspwm_pkg::COUNT_W-1:0] period_start,
   input  wire logic [bsspwm_pkg::COUNT_W-1:0] count_next,
   output logic      [bsspwm_pkg::LEVEL_W-1:0] levels
);
   import bsspwm_pkg::*;

   logic [COUNT_W-1:0] pend_ff [Channels];
   logic [COUNT_W-1:0] pend_in [Channels];
   logic [COUNT_W-1:0] act_ff  [Channels];
   logic [COUNT_W-1:0] act_in  [Channels];
   logic [Channels-1:0] en_ff;
   logic [Channels-1:0] en_in;
   logic [Channels-1:0] chan_lvl;

   always_comb begin
      for (int i = 0; i < Channels; i++) begin
         pend_in[i] = pend_ff[i];
         act_in[i]  = act_ff[i];
         en_in[i]   = en_ff[i];
         if (ctrl.write_en && (ctrl.write_sel == INDEX_W'(i))) begin
            pend_in[i] = ctrl.duty + period_start;
            en_in[i]   = (ctrl.duty != '0);
         end
         if (ctrl.load_en) begin
            act_in[i] = pend_ff[i];
         end
         chan_lvl[i] = en_in[i] &&
                       ((count_next < act_in[i]) || (act_in[i] < period_start));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Channels; i++) begin
            pend_ff[i] <= '0;
            act_ff[i]  <= '0;
         end
         en_ff <= '1;
      end else begin
         for (int i = 0; i < Channels; i++) begin
            pend_ff[i] <= pend_in[i];
            act_ff[i]  <= act_in[i];
         end
         en_ff <= en_in;
      end
   end

   for (genvar j = 0; j < LEVEL_W; j++) begin : g_lvl
      if (j < Channels) begin : g_on
         assign levels[j] = chan_lvl[j];
      end else begin : g_off
         assign levels[j] = 1'b0;
      end
   end

endmodule

`default_nettype wire
